FILE: rtl/core/dne_pkg.sv
// ----------------------------------------------------------------------------
// dne_pkg
// shared types, codes and helpers for the drainage network extraction block
// ----------------------------------------------------------------------------
package dne_pkg;

  // raster size defaults
  localparam int unsigned MaxWidthDefault  = 256;
  localparam int unsigned MaxHeightDefault = 256;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned PosW     = 8;
  localparam int unsigned ValW     = 32;
  localparam int unsigned DirW     = 4;
  localparam int unsigned ClassW   = 2;
  localparam int unsigned WordW    = DirW + ClassW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned GridW    = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE        = 2'd0,
    REG_GLOBAL_THR  = 2'd1,
    REG_GRID_WIDTH  = 2'd2,
    REG_GRID_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 2'd0,
    OP_EXTEND = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [ClassW-1:0] {
    CLS_UNDEF  = 2'd0,
    CLS_LAND   = 2'd1,
    CLS_STREAM = 2'd2
  } pixel_class_e;

  typedef enum logic [1:0] {
    EXT_IDLE,
    EXT_SCAN,
    EXT_FOLLOW
  } ext_state_e;

  // two-bit signed steps
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  // codes 1..8 are E SE S SW W NW N NE, everything else is no flow
  function automatic logic dir_ok(input logic [DirW-1:0] dir);
    dir_ok = (dir >= 4'd1) && (dir <= 4'd8);
  endfunction

  function automatic logic [1:0] step_dx(input logic [DirW-1:0] dir);
    case (dir)
      4'd1, 4'd2, 4'd8: step_dx = STEP_POS;
      4'd4, 4'd5, 4'd6: step_dx = STEP_NEG;
      default:          step_dx = STEP_ZERO;
    endcase
  endfunction

  // y grows downward
  function automatic logic [1:0] step_dy(input logic [DirW-1:0] dir);
    case (dir)
      4'd2, 4'd3, 4'd4: step_dy = STEP_POS;
      4'd6, 4'd7, 4'd8: step_dy = STEP_NEG;
      default:          step_dy = STEP_ZERO;
    endcase
  endfunction

endpackage

FILE: rtl/core/dne_intf.sv
// ----------------------------------------------------------------------------
// dne channel interfaces
// valid/ready channels for pixel items, class results and register writes
// ----------------------------------------------------------------------------
interface dne_in_if;
  logic                          valid;
  logic                          ready;
  logic [dne_pkg::OpW-1:0]       op;
  logic [dne_pkg::PosW-1:0]      x_position;
  logic [dne_pkg::PosW-1:0]      y_position;
  logic [dne_pkg::ValW-1:0]      accumulation;
  logic                          accumulation_undefined;
  logic [dne_pkg::ValW-1:0]      local_threshold;
  logic                          local_threshold_undefined;
  logic [dne_pkg::DirW-1:0]      flow_direction;

  modport source (
    output valid, op, x_position, y_position, accumulation, accumulation_undefined,
           local_threshold, local_threshold_undefined, flow_direction,
    input  ready
  );
  modport sink (
    input  valid, op, x_position, y_position, accumulation, accumulation_undefined,
           local_threshold, local_threshold_undefined, flow_direction,
    output ready
  );
endinterface

interface dne_out_if;
  logic                          valid;
  logic                          ready;
  logic [dne_pkg::ClassW-1:0]    pixel_class;

  modport source (output valid, pixel_class, input ready);
  modport sink (input valid, pixel_class, output ready);
endinterface

interface dne_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dne_pkg::CfgIdxW-1:0]   index;
  logic [dne_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/drainage_network_extraction.sv
// ----------------------------------------------------------------------------
// drainage_network_extraction
// stream network extraction from flow accumulation against a threshold
// ----------------------------------------------------------------------------
// Load items write one pixel's class (undefined, no drainage, drainage line)
// and flow direction into a single pixel store; read items return a pixel's
// class; an extend item in map mode scans the interior pixels in raster
// order and walks downstream from each stream pixel, marking the land pixels
// it walks over as stream. Loads and reads take one item per cycle while no
// extend runs and the result buffer has room; a read's class passes through
// the store's read register and then a two-entry result buffer, so a read can
// still be taken while one result waits. An extend holds off the input channel for
// every interior pixel scanned and every downstream neighbor it looks at,
// counting the neighbor that ends each walk: every such look is one access
// to the one read port of the pixel store. The store has no clearing pass;
// every pixel must be loaded before an extend or read touches it.
// Configuration registers are taken on any cycle and should be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module drainage_network_extraction #(
  parameter int unsigned MAX_WIDTH  = dne_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = dne_pkg::MaxHeightDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dne_in_if.sink    in_i,
  dne_out_if.source out_o,
  dne_cfg_if.sink   cfg_i
);

  // coordinate and address widths of the store
  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = XW + YW;
  // width wide enough for grid sizes and the saturated limits
  localparam int unsigned DWX = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DWY = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DWM = (DWX > DWY) ? DWX : DWY;
  localparam int unsigned DW  = (DWM > dne_pkg::GridW) ? DWM : dne_pkg::GridW;

  // configuration registers
  logic                        mode_q;
  logic [dne_pkg::ValW-1:0]    gthr_q;
  logic [dne_pkg::GridW-1:0]   gw_q, gh_q;

  // effective grid
  logic [DW-1:0]  eff_w, eff_h;
  logic [XW-1:0]  last_x;
  logic [YW-1:0]  last_y;
  logic           no_interior;
  logic           in_grid;

  // item handshake
  logic                        in_acc;
  logic                        is_load, is_extend, is_read;
  logic [AW-1:0]               pix_addr;
  logic [dne_pkg::ClassW-1:0]  load_cls;

  // pending user read
  logic rd_pend_q, rd_inside_q;

  // store ports
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [dne_pkg::WordW-1:0]   mem_wdata, mem_rdata;

  // extension sequencer
  logic                        ext_start, ext_busy, ext_rd_req, ext_we;
  logic [AW-1:0]               ext_raddr, ext_waddr;
  logic [dne_pkg::WordW-1:0]   ext_wdata;

  // result buffer
  logic                        buf_room;
  logic [dne_pkg::ClassW-1:0]  rd_cls;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      gthr_q <= '0;
      gw_q   <= dne_pkg::GridW'(256);
      gh_q   <= dne_pkg::GridW'(256);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dne_pkg::REG_MODE:        mode_q <= cfg_i.data[0];
        dne_pkg::REG_GLOBAL_THR:  gthr_q <= cfg_i.data;
        dne_pkg::REG_GRID_WIDTH:  gw_q   <= cfg_i.data[dne_pkg::GridW-1:0];
        dne_pkg::REG_GRID_HEIGHT: gh_q   <= cfg_i.data[dne_pkg::GridW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // effective grid size: zero counts as one, large sizes clip to the store
  // ---------------------------------------------------------------------------
  always_comb begin
    if (gw_q == '0) begin
      eff_w = DW'(1);
    end else if (DW'(gw_q) > DW'(MAX_WIDTH)) begin
      eff_w = DW'(MAX_WIDTH);
    end else begin
      eff_w = DW'(gw_q);
    end
    if (gh_q == '0) begin
      eff_h = DW'(1);
    end else if (DW'(gh_q) > DW'(MAX_HEIGHT)) begin
      eff_h = DW'(MAX_HEIGHT);
    end else begin
      eff_h = DW'(gh_q);
    end
  end

  assign last_x = XW'(eff_w - 1'b1);
  assign last_y = YW'(eff_h - 1'b1);
  // fewer than three rows or columns: no interior, extend does nothing
  assign no_interior = (eff_w < DW'(3)) || (eff_h < DW'(3));
  assign in_grid     = (DW'(in_i.x_position) < eff_w) && (DW'(in_i.y_position) < eff_h);

  // ---------------------------------------------------------------------------
  // item decode
  // ---------------------------------------------------------------------------
  // hold off while an extend runs or when the result buffer could overflow
  assign in_i.ready = !ext_busy && buf_room;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    is_load   = 1'b0;
    is_extend = 1'b0;
    is_read   = 1'b0;
    unique case (in_i.op)
      dne_pkg::OP_LOAD:   is_load   = 1'b1;
      dne_pkg::OP_EXTEND: is_extend = 1'b1;
      dne_pkg::OP_READ:   is_read   = 1'b1;
      default: ;
    endcase
  end

  assign pix_addr = {YW'(in_i.y_position), XW'(in_i.x_position)};

  // class of a loaded pixel under the mode in force now
  always_comb begin
    if (in_i.accumulation_undefined || (mode_q && in_i.local_threshold_undefined)) begin
      load_cls = dne_pkg::CLS_UNDEF;
    end else if (mode_q) begin
      load_cls = (in_i.accumulation > in_i.local_threshold) ? dne_pkg::CLS_STREAM
                                                            : dne_pkg::CLS_LAND;
    end else begin
      load_cls = (in_i.accumulation > gthr_q) ? dne_pkg::CLS_STREAM : dne_pkg::CLS_LAND;
    end
  end

  // extend only acts in map mode
  assign ext_start = in_acc && is_extend && mode_q;

  // ---------------------------------------------------------------------------
  // store port sharing: the sequencer owns the store while it runs
  // ---------------------------------------------------------------------------
  assign mem_raddr = ext_rd_req ? ext_raddr : pix_addr;
  assign mem_we    = ext_we || (in_acc && is_load && in_grid);
  assign mem_waddr = ext_we ? ext_waddr : pix_addr;
  assign mem_wdata = ext_we ? ext_wdata : {in_i.flow_direction, load_cls};

  dne_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dne_extend #(
    .XW (XW),
    .YW (YW)
  ) u_extend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ext_start),
    .small_i  (no_interior),
    .last_x_i (last_x),
    .last_y_i (last_y),
    .rdata_i  (mem_rdata),
    .busy_o   (ext_busy),
    .rd_req_o (ext_rd_req),
    .raddr_o  (ext_raddr),
    .we_o     (ext_we),
    .waddr_o  (ext_waddr),
    .wdata_o  (ext_wdata)
  );

  // ---------------------------------------------------------------------------
  // read results: store data is registered and arrives in the cycle after the read item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= in_acc && is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_inside_q <= in_grid;
  end

  // pixels outside the grid read as undefined
  assign rd_cls = rd_inside_q ? mem_rdata[dne_pkg::ClassW-1:0] : dne_pkg::CLS_UNDEF;

  dne_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rd_pend_q),
    .push_data_i (rd_cls),
    .pop_i       (out_o.ready),
    .valid_o     (out_o.valid),
    .data_o      (out_o.pixel_class),
    .room_o      (buf_room)
  );

endmodule

FILE: rtl/core/dne_mem.sv
// ----------------------------------------------------------------------------
// dne_mem
// pixel store: class and flow direction per pixel, one write and one
// registered read per cycle, write data forwarded on a same-address read
// ----------------------------------------------------------------------------
module dne_mem #(
  parameter int unsigned AW = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [dne_pkg::WordW-1:0]  wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [dne_pkg::WordW-1:0]  rdata_o
);

  localparam int unsigned Depth = 2 ** AW;

  logic [dne_pkg::WordW-1:0] mem [Depth];
  logic [dne_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/dne_extend.sv
// ----------------------------------------------------------------------------
// dne_extend
// dead-end extension sequencer: scans interior pixels and walks downstream
// from each stream pixel, marking pixels as stream through the pixel store
// ----------------------------------------------------------------------------
module dne_extend #(
  parameter int unsigned XW = 8,
  parameter int unsigned YW = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       small_i,
  input  logic [XW-1:0]              last_x_i,
  input  logic [YW-1:0]              last_y_i,
  input  logic [dne_pkg::WordW-1:0]  rdata_i,
  output logic                       busy_o,
  output logic                       rd_req_o,
  output logic [YW+XW-1:0]           raddr_o,
  output logic                       we_o,
  output logic [YW+XW-1:0]           waddr_o,
  output logic [dne_pkg::WordW-1:0]  wdata_o
);

  dne_pkg::ext_state_e state_q, state_d;

  logic [XW-1:0] sx_q, sx_d, fx_q, fx_d;
  logic [YW-1:0] sy_q, sy_d, fy_q, fy_d;

  logic [dne_pkg::ClassW-1:0] cls;
  logic [dne_pkg::DirW-1:0]   dir;
  logic [XW-1:0]              x_end, nsx, sx_nb, fx_nb;
  logic [YW-1:0]              y_end, nsy, sy_nb, fy_nb;
  logic                       scan_last, start_follow, f_stop, f_cont;

  assign cls = rdata_i[dne_pkg::ClassW-1:0];
  assign dir = rdata_i[dne_pkg::WordW-1:dne_pkg::ClassW];

  // interior runs from 1 to last-1
  assign x_end     = XW'(last_x_i - 1'b1);
  assign y_end     = YW'(last_y_i - 1'b1);
  assign scan_last = (sx_q == x_end) && (sy_q == y_end);
  assign nsx       = (sx_q == x_end) ? XW'(1) : XW'(sx_q + 1'b1);
  assign nsy       = (sx_q == x_end) ? YW'(sy_q + 1'b1) : sy_q;

  // downstream neighbor of the scan pixel and of the walk pixel
  assign sx_nb = sx_q + XW'($signed(dne_pkg::step_dx(dir)));
  assign sy_nb = sy_q + YW'($signed(dne_pkg::step_dy(dir)));
  assign fx_nb = fx_q + XW'($signed(dne_pkg::step_dx(dir)));
  assign fy_nb = fy_q + YW'($signed(dne_pkg::step_dy(dir)));

  assign start_follow = (cls == dne_pkg::CLS_STREAM) && dne_pkg::dir_ok(dir);
  assign f_stop = (cls == dne_pkg::CLS_STREAM) || (cls == dne_pkg::CLS_UNDEF) ||
                  (fx_q == '0) || (fy_q == '0) || (fx_q == last_x_i) || (fy_q == last_y_i);
  assign f_cont = !f_stop && dne_pkg::dir_ok(dir);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dne_pkg::EXT_IDLE: begin
        if (start_i && !small_i) begin
          state_d = dne_pkg::EXT_SCAN;
        end
      end
      dne_pkg::EXT_SCAN: begin
        if (start_follow) begin
          state_d = dne_pkg::EXT_FOLLOW;
        end else if (scan_last) begin
          state_d = dne_pkg::EXT_IDLE;
        end
      end
      dne_pkg::EXT_FOLLOW: begin
        if (!f_cont) begin
          state_d = scan_last ? dne_pkg::EXT_IDLE : dne_pkg::EXT_SCAN;
        end
      end
      default: state_d = dne_pkg::EXT_IDLE;
    endcase
  end

  // outputs and walk registers
  always_comb begin
    sx_d     = sx_q;
    sy_d     = sy_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    rd_req_o = 1'b0;
    raddr_o  = {sy_q, sx_q};
    we_o     = 1'b0;
    waddr_o  = {fy_q, fx_q};
    wdata_o  = {dir, dne_pkg::CLS_STREAM};
    unique case (state_q)
      dne_pkg::EXT_IDLE: begin
        if (start_i && !small_i) begin
          sx_d     = XW'(1);
          sy_d     = YW'(1);
          rd_req_o = 1'b1;
          raddr_o  = {YW'(1), XW'(1)};
        end
      end
      dne_pkg::EXT_SCAN: begin
        if (start_follow) begin
          fx_d     = sx_nb;
          fy_d     = sy_nb;
          rd_req_o = 1'b1;
          raddr_o  = {sy_nb, sx_nb};
        end else if (!scan_last) begin
          sx_d     = nsx;
          sy_d     = nsy;
          rd_req_o = 1'b1;
          raddr_o  = {nsy, nsx};
        end
      end
      dne_pkg::EXT_FOLLOW: begin
        we_o = !f_stop;
        if (f_cont) begin
          fx_d     = fx_nb;
          fy_d     = fy_nb;
          rd_req_o = 1'b1;
          raddr_o  = {fy_nb, fx_nb};
        end else if (!scan_last) begin
          sx_d     = nsx;
          sy_d     = nsy;
          rd_req_o = 1'b1;
          raddr_o  = {nsy, nsx};
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != dne_pkg::EXT_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dne_pkg::EXT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;
    sy_q <= sy_d;
    fx_q <= fx_d;
    fy_q <= fy_d;
  end

endmodule

FILE: rtl/core/dne_out_buf.sv
// ----------------------------------------------------------------------------
// dne_out_buf
// two-entry result buffer with room tracking for reads still in the store
// ----------------------------------------------------------------------------
module dne_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [dne_pkg::ClassW-1:0]  push_data_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output logic [dne_pkg::ClassW-1:0]  data_o,
  output logic                        room_o
);

  logic [dne_pkg::ClassW-1:0] ent_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       pop;
  logic [2:0]                 after;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  // a push landing now is counted, so one more read fits only below two
  assign after  = 3'(cnt_q) + 3'(push_i) - 3'(pop);
  assign room_o = (after < 3'd2);
  assign cnt_d  = after[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
